// File: rtl/core/sqtc_pkg.sv
package sqtc_pkg;

  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h58;  // 'X'

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SHOW
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic write;    // store incoming word
    logic fetch;    // read store at current position into output register
    logic advance;  // step to next output position
    logic finish;   // block done, clear message state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;     // output register holds final word of block
  } status_t;

endpackage

// File: rtl/core/sqtc_ctrl.sv
module sqtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  sqtc_pkg::status_t stat,
  output sqtc_pkg::cmd_t    cmd
);

  sqtc_pkg::state_t state;
  sqtc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqtc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sqtc_pkg::ST_LOAD: begin
        if (s_tvalid && s_tlast) state_next = sqtc_pkg::ST_FETCH;
      end
      sqtc_pkg::ST_FETCH: begin
        state_next = sqtc_pkg::ST_SHOW;
      end
      sqtc_pkg::ST_SHOW: begin
        if (m_tready) begin
          state_next = stat.last ? sqtc_pkg::ST_LOAD : sqtc_pkg::ST_FETCH;
        end
      end
      default: state_next = sqtc_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    cmd         = '0;
    case (state)
      sqtc_pkg::ST_LOAD: begin
        s_tready  = 1'b1;
        cmd.write = s_tvalid;
      end
      sqtc_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      sqtc_pkg::ST_SHOW: begin
        m_tvalid    = 1'b1;
        cmd.advance = m_tready && !stat.last;
        cmd.finish  = m_tready && stat.last;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // input and output sides never open together
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output both active");

  // a fetch is always followed by a shown word
  a_fetch_show: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> m_tvalid)
    else $error("fetched word not presented");

  // after the final word is taken, loading resumes
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> s_tready)
    else $error("block end did not return to load");

endmodule

// File: rtl/core/sqtc_dp.sv
module sqtc_dp #(
  parameter int MAX_SIDE = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sqtc_pkg::cmd_t              cmd,
  output sqtc_pkg::status_t           stat,
  input  logic [sqtc_pkg::CHAR_W-1:0] in_char,
  input  logic                        mode_we,
  input  logic                        mode_wdata,
  output logic [sqtc_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last,
  output logic                        overflow
);

  localparam int CAP = MAX_SIDE * MAX_SIDE;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);
  localparam int SW  = $clog2(MAX_SIDE + 1);

  logic [sqtc_pkg::CHAR_W-1:0] mem [CAP];

  logic [CW-1:0] count;
  logic          dropped;
  logic [SW-1:0] side;
  logic [CW-1:0] sq;         // side*side, kept incrementally
  logic [SW-1:0] row;        // m mod side
  logic [SW-1:0] col;        // m div side
  logic [CW-1:0] base;       // row*side
  logic [CW-1:0] idx;
  logic          mode;       // held only; transpose is its own inverse

  logic [sqtc_pkg::CHAR_W-1:0] rd_char;
  logic                        pad;

  assign idx = base + CW'(col);

  always_ff @(posedge clk) begin
    if (cmd.write && (count < CW'(CAP))) begin
      mem[count[AW-1:0]] <= in_char;
    end
    if (cmd.fetch) begin
      rd_char <= mem[idx[AW-1:0]];
      pad     <= !(idx < count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      side     <= SW'(1);
      sq       <= CW'(1);
      row      <= '0;
      col      <= '0;
      base     <= '0;
      mode     <= 1'b0;
      out_last <= 1'b0;
      overflow <= 1'b0;
    end else begin
      if (mode_we) mode <= mode_wdata;
      if (cmd.write) begin
        if (count < CW'(CAP)) begin
          count <= count + CW'(1);
          // ceil(sqrt) grows by one when the count passes the square
          if (count >= sq) begin
            side <= side + SW'(1);
            sq   <= sq + CW'({side, 1'b1});
          end
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.fetch) begin
        out_last <= (row == side - SW'(1)) && (col == side - SW'(1));
        overflow <= dropped;
      end
      if (cmd.advance) begin
        if (row == side - SW'(1)) begin
          row  <= '0;
          base <= '0;
          col  <= col + SW'(1);
        end else begin
          row  <= row + SW'(1);
          base <= base + CW'(side);
        end
      end
      if (cmd.finish) begin
        count   <= '0;
        dropped <= 1'b0;
        side    <= SW'(1);
        sq      <= CW'(1);
        row     <= '0;
        col     <= '0;
        base    <= '0;
      end
    end
  end

  assign out_char  = pad ? sqtc_pkg::PAD_CHAR : rd_char;
  assign stat.last = out_last;

  a_sq_track: assert property (@(posedge clk) disable iff (rst)
    32'(sq) == 32'(side) * 32'(side))
    else $error("square register out of step with side");

  a_side_ceil: assert property (@(posedge clk) disable iff (rst)
    count <= sq && (count == '0 || (32'(side) - 1) * (32'(side) - 1) < 32'(count)))
    else $error("side is not ceil(sqrt(count))");

  a_base_track: assert property (@(posedge clk) disable iff (rst)
    32'(base) == 32'(row) * 32'(side))
    else $error("row base out of step");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == '0 && !dropped))
    else $error("message state not cleared");

endmodule

// File: rtl/core/square_transposition_cipher.sv
// Square transposition cipher. Characters arrive one word per cycle on the
// s_ side while the block is loading; the word with s_tlast set closes the
// message. The block then takes side = ceil(sqrt(count)), pads the message
// to side*side with 'X' and emits that square transposed on the m_ side:
// output m is the padded message at (m mod side)*side + (m div side).
// m_tlast marks the final word and m_tuser is set on every word of a block
// whose message ran past MAX_SIDE*MAX_SIDE characters (the excess is
// dropped; a dropped last character still ends the message). Timing: each
// output word takes a store read (FETCH) and then a stay in the output
// register (SHOW) until m_tready. The output pace is set by the controller,
// which starts the next store read only after the current word is taken.
// Input is not taken while a block is being emitted. mode (encrypt/decrypt)
// is stored but does not change the output, since the transpose is its own
// inverse; write it only while the block is idle.
module square_transposition_cipher #(
  parameter int MAX_SIDE = 8     // 1..8
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] in_char
  input  logic       s_tlast,    // in_last
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] out_char
  output logic       m_tlast,    // out_last
  output logic       m_tuser,    // [0] overflow
  // mode register
  input  logic       mode_we,
  input  logic       mode_wdata
);

  sqtc_pkg::cmd_t    cmd;
  sqtc_pkg::status_t stat;

  // sequencing: load, then fetch/show per output word
  sqtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, square tracking, transposed addressing, output register
  sqtc_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (s_tdata),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .out_char   (m_tdata),
    .out_last   (m_tlast),
    .overflow   (m_tuser)
  );

endmodule

// File: bench/transpose_checker.sv
`timescale 1ns / 100ps
module transpose_checker #(
  parameter int MAX_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        m_tuser,
  input  logic        mode_we,
  input  logic        mode_wdata,
  output int unsigned errors,
  output int unsigned words_owed
);

  localparam int unsigned CAPACITY = MAX_SIDE * MAX_SIDE;

  typedef struct packed {
    logic [sqtc_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic                        overflow;
  } cipher_word_t;

  logic [sqtc_pkg::CHAR_W-1:0] msg_chars [CAPACITY];
  int unsigned       msg_len = 0;
  logic              msg_lost = 1'b0;
  logic              mode_shadow = 1'b0;  // kept only; transpose is self-inverse
  int unsigned       mismatches = 0;
  cipher_word_t      owed_q [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 50)
      $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // side = ceil(sqrt(len)), pad with 'X', queue the square column by column
  task automatic push_transposed_block();
    int unsigned  side;
    int unsigned  total;
    int unsigned  idx;
    int unsigned  m;
    cipher_word_t w;
    side = 1;
    while (side * side < msg_len)
      side++;
    total = side * side;
    for (m = 0; m < total; m++) begin
      idx        = (m % side) * side + m / side;
      w.ch       = (idx < msg_len) ? msg_chars[idx] : sqtc_pkg::PAD_CHAR;
      w.last     = (m + 1 == total);
      w.overflow = msg_lost;
      owed_q.insert(owed_q.size(), w);
    end
    msg_len  = 0;
    msg_lost = 1'b0;
  endtask

  task automatic take_char();
    if (msg_len < CAPACITY) begin
      msg_chars[msg_len] = s_tdata;
      msg_len++;
    end else begin
      msg_lost = 1'b1;
    end
    if (s_tlast)
      push_transposed_block();
  endtask

  task automatic check_word();
    cipher_word_t want;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word char=%02h last=%0b ovf=%0b",
                                m_tdata, m_tlast, m_tuser));
    end else begin
      want = owed_q.pop_front();
      if (m_tdata !== want.ch)
        report_mismatch($sformatf("char got %02h want %02h", m_tdata, want.ch));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
      if (m_tuser !== want.overflow)
        report_mismatch($sformatf("overflow got %0b want %0b", m_tuser, want.overflow));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      msg_len     = 0;
      msg_lost    = 1'b0;
      mode_shadow = 1'b0;
      owed_q.delete();
    end else begin
      if (mode_we)
        mode_shadow = mode_wdata;
      if (m_tvalid && m_tready)
        check_word();
      if (s_tvalid && s_tready)
        take_char();
    end
    errors     <= mismatches;
    words_owed <= owed_q.size();
  end

endmodule

// File: bench/tb_square_transposition_cipher.sv
`timescale 1ns / 100ps
module tb_square_transposition_cipher;

  localparam int          MAX_SIDE     = 8;
  localparam int unsigned CAPACITY     = MAX_SIDE * MAX_SIDE;
  localparam int unsigned TARGET_CHARS = 260;   // stop offering after this many
  localparam int unsigned HOLD_CYCLES  = 300;   // long output hold-off
  localparam int unsigned TAIL_CYCLES  = 20;    // drain after last expected word

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata    = '0;
  logic        s_tlast    = 1'b0;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        mode_we    = 1'b0;
  logic        mode_wdata = 1'b0;

  int unsigned errors;
  int unsigned words_owed;

  // flipped by the stimulus to ask the sink for a long hold-off
  logic        hold_toggle = 1'b0;

  // stimulus bookkeeping, touched by the stimulus process only
  int unsigned chars_sent = 0;
  int unsigned burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  square_transposition_cipher #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [7:0] in_char
    .s_tlast   (s_tlast),     // in_last
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [7:0] out_char
    .m_tlast   (m_tlast),     // out_last
    .m_tuser   (m_tuser),     // [0] overflow
    .mode_we   (mode_we),
    .mode_wdata(mode_wdata)
  );

  // Watches both streams, predicts the transposed block and compares.
  transpose_checker #(
    .MAX_SIDE(MAX_SIDE)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .mode_we   (mode_we),
    .mode_wdata(mode_wdata),
    .errors    (errors),
    .words_owed(words_owed)
  );

  // Sink: runs in segments of random length, each with its own stall shape.
  // A flip of hold_toggle forces HOLD_CYCLES of m_tready low, so the block
  // backs up and stops taking input while the source keeps offering.
  initial begin : sink_pattern
    int unsigned seg_left;
    int unsigned sink_kind;
    int unsigned hold_left;
    int unsigned tick;
    logic        seen_toggle;
    seg_left    = 0;
    sink_kind   = 0;
    hold_left   = 0;
    tick        = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        sink_kind = $urandom_range(0, 3);
        seg_left  = $urandom_range(8, 80);
      end
      seg_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (sink_kind)
          0: begin
            m_tready <= 1'b1;                            // no backpressure
          end
          1: begin
            m_tready <= 1'($urandom_range(0, 1));        // coin flip
          end
          2: begin
            m_tready <= (tick % 4 == 0);                 // one cycle in four
          end
          default: begin
            m_tready <= ($urandom_range(0, 7) != 0);     // rare stall
          end
        endcase
      end
    end
  end

  // Offer one word; the source runs in bursts with random gaps between them.
  // Returns in the step right after the word was taken.
  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    chars_sent++;
  endtask

  // A message of len random characters, last flag on the final one.
  task automatic send_message(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++)
      send_char(8'($urandom_range(0, 255)), i + 1 == len);
  endtask

  // Mode write only with the block idle: drain every owed word, let the
  // block settle back to loading, then one write-enable pulse.
  task automatic write_mode(input logic value);
    s_tvalid <= 1'b0;
    @(posedge clk);                     // owed count now covers the last word
    while (words_owed != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    mode_we    <= 1'b1;
    mode_wdata <= value;
    @(posedge clk);
    mode_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned msg_no;
    int unsigned len;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b1);

    // directed: single-character messages at both extremes, a short message
    // with padding, then exact and inexact squares
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b1);
    send_message(3);
    send_message(4);
    send_message(5);
    send_message(9);

    // pause until every owed word is back, then flip the mode
    write_mode(1'b0);

    // random messages, mostly short; a few fill or overrun the store
    msg_no = 0;
    while (chars_sent < TARGET_CHARS) begin
      if (msg_no == 4)
        hold_toggle <= ~hold_toggle;
      if (msg_no == 12)
        write_mode(1'b1);
      if (msg_no == 24)
        write_mode(1'b0);
      if (msg_no == 2)
        len = CAPACITY + 1;          // final word dropped, still ends message
      else if (msg_no == 7)
        len = CAPACITY;              // full square, nothing lost
      else if ($urandom_range(0, 24) == 0)
        len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
      else
        len = $urandom_range(1, 16);
      send_message(len);
      msg_no++;
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (words_owed != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && words_owed == 0)
      $display("[square_transposition_cipher] OK");
    else
      $display("[square_transposition_cipher] ERROR");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #(2_000_000);
    $display("[square_transposition_cipher] ERROR");
    $finish;
  end

endmodule
